@@ src/fcca_pkg.sv @@
// ----------------------------------------------------------------------------
// fcca_pkg
// Shared widths, link codes, word types and control structs of the cluster
// chain allocator.
// ----------------------------------------------------------------------------
package fcca_pkg;

  localparam int NUM_CLUSTERS  = 512;
  localparam int CLUSTER_BYTES = 2048;
  localparam int TABLE_SLOT    = 1;
  localparam int ROOT_SLOT     = 2;

  localparam int CMD_W     = 2;
  localparam int SIZE_W    = 21;
  localparam int CLUSTER_W = 9;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 10;
  localparam int LINK_W    = 11;

  localparam int IDX_W    = $clog2(NUM_CLUSTERS);
  localparam int CNT_W    = $clog2(NUM_CLUSTERS + 1);
  localparam int BYTE_SH  = $clog2(CLUSTER_BYTES);

  localparam logic [LINK_W-1:0] CODE_FREE = LINK_W'(NUM_CLUSTERS);
  localparam logic [LINK_W-1:0] CODE_END  = LINK_W'(NUM_CLUSTERS + 1);
  localparam logic [LINK_W-1:0] CODE_RESV = LINK_W'(NUM_CLUSTERS + 2);

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BADCL   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [SIZE_W-1:0]    size_bytes;
    logic [CLUSTER_W-1:0] cluster;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [CLUSTER_W-1:0] result_cluster;
    logic                 chain_end;
    logic [COUNT_W-1:0]   chain_len;
  } out_word_t;

  typedef enum logic [2:0] {
    RES_NONE     = 3'd0,
    RES_ZERO     = 3'd1,
    RES_NOSPACE  = 3'd2,
    RES_BADCL    = 3'd3,
    RES_ALLOC_OK = 3'd4,
    RES_FREE_OK  = 3'd5,
    RES_LOOK     = 3'd6
  } res_sel_e;

  typedef struct packed {
    logic     latch;
    logic     init;
    logic     scan;
    logic     link;
    logic     tail;
    logic     free_wr;
    logic     load_out;
    res_sel_e res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic in_over;
    logic in_cl_oor;
    logic init_done;
    logic scan_hit;
    logic scan_fail;
    logic link_done;
    logic rd_link;
    logic rd_end;
    logic cnt_zero;
    logic cnt_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [LINK_W-1:0] init_link(input logic [IDX_W-1:0] idx);
    logic [LINK_W-1:0] val;
    if (idx == IDX_W'(TABLE_SLOT) || idx == IDX_W'(ROOT_SLOT)) begin
      val = CODE_END;
    end else if (idx < IDX_W'(2)) begin
      val = CODE_RESV;
    end else begin
      val = CODE_FREE;
    end
    return val;
  endfunction

endpackage

@@ src/fcca_ram.sv @@
// ----------------------------------------------------------------------------
// fcca_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/fcca_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcca_ctrl
// Sequencer of the allocator: table sweep after reset, allocate scan and
// link passes, chain free walk, lookup and result hand-off.
// ----------------------------------------------------------------------------
module fcca_ctrl
  import fcca_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  output logic             in_ready_o,
  input  dp_stat_t         st_i,
  output dp_cmd_t          cmd_o
);

  typedef enum logic [9:0] {
    ST_INIT      = 10'b00_0000_0001,
    ST_IDLE      = 10'b00_0000_0010,
    ST_SCAN      = 10'b00_0000_0100,
    ST_LINK      = 10'b00_0000_1000,
    ST_TAIL      = 10'b00_0001_0000,
    ST_FREE_RD   = 10'b00_0010_0000,
    ST_FREE_CHK  = 10'b00_0100_0000,
    ST_FREE_DONE = 10'b00_1000_0000,
    ST_LOOK_RD   = 10'b01_0000_0000,
    ST_RESP      = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   look_chk_q, look_chk_d;

  always_comb begin
    state_d    = state_q;
    look_chk_d = 1'b0;
    in_ready_o = 1'b0;
    cmd_o      = '{latch: 1'b0, init: 1'b0, scan: 1'b0, link: 1'b0, tail: 1'b0,
                   free_wr: 1'b0, load_out: 1'b0, res_sel: RES_NONE};
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init = 1'b1;
        if (st_i.init_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          unique case (in_cmd_i)
            CMD_ALLOC: begin
              if (st_i.in_over) begin
                cmd_o.res_sel = RES_NOSPACE;
                state_d       = ST_RESP;
              end else begin
                state_d = ST_SCAN;
              end
            end
            CMD_FREE: begin
              if (st_i.in_cl_oor) begin
                cmd_o.res_sel = RES_BADCL;
                state_d       = ST_RESP;
              end else begin
                state_d = ST_FREE_RD;
              end
            end
            CMD_LOOKUP: begin
              if (st_i.in_cl_oor) begin
                cmd_o.res_sel = RES_BADCL;
                state_d       = ST_RESP;
              end else begin
                state_d = ST_LOOK_RD;
              end
            end
            default: begin
              cmd_o.res_sel = RES_ZERO;
              state_d       = ST_RESP;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (st_i.scan_hit) begin
          state_d = ST_LINK;
        end else if (st_i.scan_fail) begin
          cmd_o.res_sel = RES_NOSPACE;
          state_d       = ST_RESP;
        end
      end
      ST_LINK: begin
        cmd_o.link = 1'b1;
        if (st_i.link_done) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        cmd_o.tail    = 1'b1;
        cmd_o.res_sel = RES_ALLOC_OK;
        state_d       = ST_RESP;
      end
      ST_FREE_RD: begin
        state_d = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        if (st_i.rd_link || st_i.rd_end) begin
          cmd_o.free_wr = 1'b1;
          if (st_i.rd_link && !st_i.cnt_last) begin
            state_d = ST_FREE_RD;
          end else begin
            state_d = ST_FREE_DONE;
          end
        end else if (st_i.cnt_zero) begin
          cmd_o.res_sel = RES_BADCL;
          state_d       = ST_RESP;
        end else begin
          state_d = ST_FREE_DONE;
        end
      end
      ST_FREE_DONE: begin
        cmd_o.res_sel = RES_FREE_OK;
        state_d       = ST_RESP;
      end
      ST_LOOK_RD: begin
        look_chk_d = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        if (look_chk_q) begin
          cmd_o.res_sel = RES_LOOK;
          look_chk_d    = 1'b0;
        end else if (st_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
        if (look_chk_q) begin
          state_d = ST_RESP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      look_chk_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      look_chk_q <= look_chk_d;
    end
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> st_i.out_free)
    else $error("result word loaded while output register is occupied");

  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.init |-> !in_ready_o && !cmd_o.latch)
    else $error("input word taken during table sweep");

endmodule

@@ src/fcca_dpath.sv @@
// ----------------------------------------------------------------------------
// fcca_dpath
// Datapath of the allocator: link table RAM, scan and walk counters, result
// staging and output register.
// ----------------------------------------------------------------------------
module fcca_dpath
  import fcca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_i,
  input  dp_cmd_t   cmd_i,
  output dp_stat_t  st_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_o
);

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [LINK_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [LINK_W-1:0] ram_rdata;

  logic [CNT_W-1:0] rd_addr_q, rd_addr_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0] chk_addr_q, chk_addr_d;
  logic [CNT_W-1:0] found_q, found_d;
  logic [CNT_W-1:0] need_q, need_d;
  logic [IDX_W-1:0] first_q, first_d;
  logic [IDX_W-1:0] last_q, last_d;
  logic [IDX_W-1:0] prev_q, prev_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  out_word_t        res_q, res_d;
  out_word_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [SIZE_W:0]  round_sum;
  logic [SIZE_W:0]  need_full;
  logic             rd_free;
  logic             rd_link;
  logic             rd_end;
  logic             scan_issue;
  logic             link_issue;
  logic             scan_take;
  logic             scan_hit;
  logic [CNT_W-1:0] found_inc;
  logic [IDX_W-1:0] first_now;
  logic             link_we;

  fcca_ram #(
    .WIDTH(LINK_W),
    .DEPTH(NUM_CLUSTERS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign round_sum = {1'b0, in_i.size_bytes} + (SIZE_W + 1)'(CLUSTER_BYTES - 1);
  assign need_full = (in_i.size_bytes == '0) ? (SIZE_W + 1)'(1) : (round_sum >> BYTE_SH);

  assign rd_free = ram_rdata == CODE_FREE;
  assign rd_link = ram_rdata < LINK_W'(NUM_CLUSTERS);
  assign rd_end  = ram_rdata == CODE_END;

  assign scan_issue = rd_addr_q < CNT_W'(NUM_CLUSTERS);
  assign link_issue = rd_addr_q <= CNT_W'(last_q);
  assign scan_take  = chk_vld_q && rd_free;
  assign found_inc  = found_q + CNT_W'(1);
  assign scan_hit   = cmd_i.scan && scan_take && (found_inc == need_q);
  assign first_now  = (found_q == '0) ? chk_addr_q : first_q;
  assign link_we    = cmd_i.link && chk_vld_q && rd_free && (chk_addr_q != prev_q);

  assign st_o.in_over   = need_full > (SIZE_W + 1)'(NUM_CLUSTERS);
  assign st_o.in_cl_oor = int'(in_i.cluster) >= NUM_CLUSTERS;
  assign st_o.init_done = rd_addr_q == CNT_W'(NUM_CLUSTERS - 1);
  assign st_o.scan_hit  = scan_hit;
  assign st_o.scan_fail = !chk_vld_q && (rd_addr_q == CNT_W'(NUM_CLUSTERS));
  assign st_o.link_done = chk_vld_q && (chk_addr_q == last_q);
  assign st_o.rd_link   = rd_link;
  assign st_o.rd_end    = rd_end;
  assign st_o.cnt_zero  = cnt_q == '0;
  assign st_o.cnt_last  = cnt_q == CNT_W'(NUM_CLUSTERS - 1);
  assign st_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    rd_addr_d   = rd_addr_q;
    chk_vld_d   = 1'b0;
    chk_addr_d  = chk_addr_q;
    found_d     = found_q;
    need_d      = need_q;
    first_d     = first_q;
    last_d      = last_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_q;
    ram_wdata   = CODE_FREE;
    ram_raddr   = cur_q;

    if (cmd_i.latch) begin
      rd_addr_d = '0;
      found_d   = '0;
      cnt_d     = '0;
      cur_d     = IDX_W'(in_i.cluster);
      need_d    = CNT_W'(need_full);
    end

    if (cmd_i.init) begin
      ram_we    = 1'b1;
      ram_waddr = rd_addr_q[IDX_W-1:0];
      ram_wdata = init_link(rd_addr_q[IDX_W-1:0]);
      rd_addr_d = st_o.init_done ? '0 : rd_addr_q + CNT_W'(1);
    end

    if (cmd_i.scan) begin
      ram_raddr  = rd_addr_q[IDX_W-1:0];
      chk_vld_d  = scan_issue;
      chk_addr_d = rd_addr_q[IDX_W-1:0];
      rd_addr_d  = rd_addr_q + CNT_W'(scan_issue);
      if (scan_take) begin
        found_d = found_inc;
        first_d = first_now;
      end
      if (scan_hit) begin
        last_d    = chk_addr_q;
        prev_d    = first_now;
        rd_addr_d = CNT_W'(first_now);
        chk_vld_d = 1'b0;
      end
    end

    if (cmd_i.link) begin
      ram_raddr  = rd_addr_q[IDX_W-1:0];
      chk_vld_d  = link_issue;
      chk_addr_d = rd_addr_q[IDX_W-1:0];
      rd_addr_d  = rd_addr_q + CNT_W'(link_issue);
      if (link_we) begin
        ram_we    = 1'b1;
        ram_waddr = prev_q;
        ram_wdata = LINK_W'(chk_addr_q);
        prev_d    = chk_addr_q;
      end
    end

    if (cmd_i.tail) begin
      ram_we    = 1'b1;
      ram_waddr = last_q;
      ram_wdata = CODE_END;
    end

    if (cmd_i.free_wr) begin
      ram_we    = 1'b1;
      ram_waddr = cur_q;
      ram_wdata = CODE_FREE;
      cnt_d     = cnt_q + CNT_W'(1);
      if (rd_link) begin
        cur_d = ram_rdata[IDX_W-1:0];
      end
    end

    unique case (cmd_i.res_sel)
      RES_ZERO: begin
        res_d = '0;
      end
      RES_NOSPACE: begin
        res_d        = '0;
        res_d.status = STAT_NOSPACE;
      end
      RES_BADCL: begin
        res_d        = '0;
        res_d.status = STAT_BADCL;
      end
      RES_ALLOC_OK: begin
        res_d                = '0;
        res_d.status         = STAT_OK;
        res_d.result_cluster = CLUSTER_W'(first_q);
        res_d.chain_len      = COUNT_W'(need_q);
      end
      RES_FREE_OK: begin
        res_d           = '0;
        res_d.status    = STAT_OK;
        res_d.chain_len = COUNT_W'(cnt_q);
      end
      RES_LOOK: begin
        res_d = '0;
        if (rd_end) begin
          res_d.chain_end = 1'b1;
        end else if (rd_link) begin
          res_d.result_cluster = CLUSTER_W'(ram_rdata);
        end else begin
          res_d.status = STAT_BADCL;
        end
      end
      default: begin
        res_d = res_q;
      end
    endcase

    if (cmd_i.load_out) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q   <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_addr_q   <= rd_addr_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_addr_q <= chk_addr_d;
    found_q    <= found_d;
    need_q     <= need_d;
    first_q    <= first_d;
    last_q     <= last_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.load_out))
    else $error("output word appeared without a load");

  a_scan_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (found_q < need_q))
    else $error("scan kept running after the request was met");

  a_link_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_we |-> (prev_q < chk_addr_q) && (chk_addr_q <= last_q))
    else $error("chain link not ascending or past the last cluster");

endmodule

@@ src/fat_cluster_chain_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// fat_cluster_chain_allocator_unit
// FAT-style cluster chain allocator over a 512-entry link table.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o / in_i) takes one command word:
// allocate a chain for a byte size, free a chain from a start cluster, or
// look up the next link of a cluster. Output channel (out_valid_o /
// out_ready_i / out_o) returns one result word per command, in order.
// After reset the link table is swept once, one entry per cycle, over all
// 512 entries; in_ready_o stays low during the sweep.
// One command is in work at a time. Steps from accept to result:
//   oversized allocate or unused command: result chosen at accept
//   lookup, or free of a free or reserved cluster: one table read first
//   allocate: scan entries 0 to the last picked cluster, then a link pass
//     over the span from first to last picked cluster, then the tail write;
//     a refused scan covers the whole table
//   free: a read and a free write per freed entry, plus one more read when
//     the walk stops on a stale link
// The table RAM has one read and one write port with registered read data,
// so each free walk step has a read state and a check state.
// A finished result waits in the output register while the next command can
// be taken in the cycle after the load; a stalled receiver holds a new result
// back until the word leaves.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator_unit
  import fcca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  fcca_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_cmd_i  (in_i.cmd),
    .in_ready_o(in_ready_o),
    .st_i      (dp_stat),
    .cmd_o     (dp_cmd)
  );

  fcca_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_i      (dp_cmd),
    .st_o       (dp_stat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

endmodule

@@ dv/fcca_chain_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fcca_chain_checker
// Watches both channels of the cluster chain allocator, keeps a shadow of
// the link table, predicts one result word per accepted command and compares
// each result word, field by field, in order.
// ----------------------------------------------------------------------------
module fcca_chain_checker
  import fcca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic [LINK_W-1:0] shadow_links [NUM_CLUSTERS];
  logic [IDX_W-1:0]  picked [NUM_CLUSTERS];
  out_word_t         expected_results [$];
  out_word_t         want;

  task automatic reset_links();
    for (int i = 0; i < NUM_CLUSTERS; i++) begin
      shadow_links[i] = CODE_FREE;
    end
    shadow_links[0]          = CODE_RESV;
    shadow_links[1]          = CODE_RESV;
    shadow_links[TABLE_SLOT] = CODE_END;
    shadow_links[ROOT_SLOT]  = CODE_END;
  endtask

  function automatic out_word_t run_alloc(input logic [SIZE_W-1:0] size);
    out_word_t r;
    int        need;
    int        found;
    r = '0;
    need = (size == '0) ? 1 : (int'(size) + CLUSTER_BYTES - 1) / CLUSTER_BYTES;
    found = 0;
    for (int i = 0; i < NUM_CLUSTERS && found < need; i++) begin
      if (shadow_links[i] == CODE_FREE) begin
        picked[found] = IDX_W'(i);
        found++;
      end
    end
    if (need > NUM_CLUSTERS || found < need) begin
      r.status = STAT_NOSPACE;
      return r;
    end
    for (int i = 0; i < found; i++) begin
      if (i == found - 1) begin
        shadow_links[picked[i]] = CODE_END;
      end else begin
        shadow_links[picked[i]] = LINK_W'(picked[i+1]);
      end
    end
    r.status         = STAT_OK;
    r.result_cluster = picked[0];
    r.chain_len      = COUNT_W'(found);
    return r;
  endfunction

  function automatic out_word_t run_free(input logic [IDX_W-1:0] start);
    out_word_t         r;
    logic [IDX_W-1:0]  cur;
    logic [LINK_W-1:0] nxt;
    int                count;
    int                steps;
    bit                walking;
    r = '0;
    if (shadow_links[start] == CODE_FREE || shadow_links[start] == CODE_RESV) begin
      r.status = STAT_BADCL;
      return r;
    end
    cur     = start;
    count   = 0;
    steps   = 0;
    walking = 1'b1;
    while (walking && steps < NUM_CLUSTERS) begin
      nxt = shadow_links[cur];
      if (nxt == CODE_FREE || nxt >= CODE_RESV) begin
        walking = 1'b0;
      end else begin
        shadow_links[cur] = CODE_FREE;
        count++;
        if (nxt == CODE_END) begin
          walking = 1'b0;
        end else begin
          cur = nxt[IDX_W-1:0];
        end
      end
      steps++;
    end
    r.status    = STAT_OK;
    r.chain_len = COUNT_W'(count);
    return r;
  endfunction

  function automatic out_word_t run_lookup(input logic [IDX_W-1:0] idx);
    out_word_t r;
    r = '0;
    if (shadow_links[idx] == CODE_END) begin
      r.chain_end = 1'b1;
    end else if (shadow_links[idx] < CODE_FREE) begin
      r.result_cluster = shadow_links[idx][IDX_W-1:0];
    end else begin
      r.status = STAT_BADCL;
    end
    return r;
  endfunction

  function automatic out_word_t predict_word(input in_word_t w);
    out_word_t r;
    case (w.cmd)
      CMD_ALLOC:  r = run_alloc(w.size_bytes);
      CMD_FREE:   r = run_free(w.cluster);
      CMD_LOOKUP: r = run_lookup(w.cluster);
      default:    r = '0;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_links();
      expected_results.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result word with no command outstanding");
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_i.status));
          check_field("result_cluster", 32'(want.result_cluster),
                      32'(out_i.result_cluster));
          check_field("chain_end", 32'(want.chain_end), 32'(out_i.chain_end));
          check_field("chain_len", 32'(want.chain_len), 32'(out_i.chain_len));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_word(in_i));
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, free, lookup and unused commands into the chain allocator:
// a directed opening over empty, partial and full tables, then random words
// under changing idle and stall patterns with one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import fcca_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
  localparam int               HOLD_CYCLES  = 3000;
  localparam int               RANDOM_WORDS = 560;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;
  int        fail_count;
  int        pending;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  bit        hold_req = 1'b0;

  always #2 clk = ~clk;

  fat_cluster_chain_allocator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_word)
  );

  fcca_chain_checker chain_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_i         (in_word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_i        (out_word),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic in_word_t cmd_word(input logic [CMD_W-1:0] cmd,
                                        input logic [SIZE_W-1:0] size,
                                        input logic [CLUSTER_W-1:0] cl);
    in_word_t w;
    w.cmd        = cmd;
    w.size_bytes = size;
    w.cluster    = cl;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      w.cmd = CMD_ALLOC;
    end else if (sel < 65) begin
      w.cmd = CMD_FREE;
    end else if (sel < 95) begin
      w.cmd = CMD_LOOKUP;
    end else begin
      w.cmd = CMD_UNUSED;
    end
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      w.size_bytes = SIZE_W'($urandom_range(0, 12 * CLUSTER_BYTES));
    end else if (sel < 85) begin
      w.size_bytes = SIZE_W'($urandom_range(1, 40) * CLUSTER_BYTES + $urandom_range(0, 2) - 1);
    end else begin
      w.size_bytes = SIZE_W'($urandom);
    end
    if ($urandom_range(0, 99) < 60) begin
      w.cluster = CLUSTER_W'($urandom_range(0, 127));
    end else begin
      w.cluster = CLUSTER_W'($urandom);
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  initial begin
    #15_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    in_word_t directed [$];
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;

    directed.push_back(cmd_word(CMD_LOOKUP, '0, 9'd0));
    directed.push_back(cmd_word(CMD_LOOKUP, '0, 9'd1));
    directed.push_back(cmd_word(CMD_LOOKUP, '0, 9'd3));
    directed.push_back(cmd_word(CMD_UNUSED, '1, '1));
    directed.push_back(cmd_word(CMD_ALLOC, 21'd0, '0));
    directed.push_back(cmd_word(CMD_ALLOC, 21'd1, '1));
    directed.push_back(cmd_word(CMD_ALLOC, 21'd2048, '0));
    directed.push_back(cmd_word(CMD_ALLOC, 21'd8192, '0));
    directed.push_back(cmd_word(CMD_ALLOC, 21'd2049, '0));
    directed.push_back(cmd_word(CMD_LOOKUP, '0, 9'd6));
    directed.push_back(cmd_word(CMD_LOOKUP, '0, 9'd9));
    directed.push_back(cmd_word(CMD_FREE, '0, 9'd8));
    directed.push_back(cmd_word(CMD_FREE, '0, 9'd6));
    directed.push_back(cmd_word(CMD_LOOKUP, '0, 9'd7));
    directed.push_back(cmd_word(CMD_FREE, '0, 9'd0));
    directed.push_back(cmd_word(CMD_FREE, '0, 9'd20));
    directed.push_back(cmd_word(CMD_ALLOC, 21'd1048576, '0));
    directed.push_back(cmd_word(CMD_ALLOC, '1, '0));
    directed.push_back(cmd_word(CMD_FREE, '0, 9'd1));
    directed.push_back(cmd_word(CMD_LOOKUP, '1, 9'd511));
    directed.push_back(cmd_word(CMD_ALLOC, 21'd1034240, '0));
    directed.push_back(cmd_word(CMD_LOOKUP, '0, 9'd511));
    directed.push_back(cmd_word(CMD_ALLOC, 21'd0, '0));
    directed.push_back(cmd_word(CMD_FREE, '0, 9'd1));
    directed.push_back(cmd_word(CMD_LOOKUP, '0, 9'd511));

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_word(directed[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          hold_req     = 1'b1;
        end
        1: begin
          tx_idle_pct  = 82;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 82;
        end
        default: begin
          tx_idle_pct  = 15;
          rx_stall_pct = 15;
        end
      endcase
      for (int n = 0; n < RANDOM_WORDS / 4; n++) send_word(random_word());
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
